// ===== sv/token_lexer_stream_top_macros.svh =====
// Assertion helpers shared by the lexer sources.
`ifndef TOKEN_LEXER_STREAM_TOP_MACROS_SVH
`define TOKEN_LEXER_STREAM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TLS_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);
// Same-cycle implication.
`define TLS_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define TLS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TLS_ASSERT(lbl, ck, rstn, prop, msg)
`define TLS_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define TLS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/tls_pkg.sv =====
package tls_pkg;

	localparam int VALUE_WIDTH    = 32;
	localparam int POSITION_WIDTH = 32;
	localparam int LENGTH_WIDTH   = 32;
	localparam int KIND_WIDTH     = 5;
	localparam int BYTE_WIDTH     = 8;
	localparam int MAX_RESULTS    = 3;
	localparam int FIFO_DEPTH     = 8;

	localparam int M_PAYLOAD_BITS = VALUE_WIDTH + 1 + POSITION_WIDTH + LENGTH_WIDTH;
	localparam int M_TDATA_WIDTH  = ((M_PAYLOAD_BITS + 7) / 8) * 8;

	localparam logic [KIND_WIDTH-1:0] TK_END     = 5'd0;
	localparam logic [KIND_WIDTH-1:0] TK_IDENT   = 5'd1;
	localparam logic [KIND_WIDTH-1:0] TK_MAP     = 5'd2;
	localparam logic [KIND_WIDTH-1:0] TK_RETURN  = 5'd3;
	localparam logic [KIND_WIDTH-1:0] TK_INT     = 5'd4;
	localparam logic [KIND_WIDTH-1:0] TK_COLON   = 5'd5;
	localparam logic [KIND_WIDTH-1:0] TK_SEMI    = 5'd6;
	localparam logic [KIND_WIDTH-1:0] TK_LPAREN  = 5'd7;
	localparam logic [KIND_WIDTH-1:0] TK_RPAREN  = 5'd8;
	localparam logic [KIND_WIDTH-1:0] TK_LBRACE  = 5'd9;
	localparam logic [KIND_WIDTH-1:0] TK_RBRACE  = 5'd10;
	localparam logic [KIND_WIDTH-1:0] TK_COMMA   = 5'd11;
	localparam logic [KIND_WIDTH-1:0] TK_PERIOD  = 5'd12;
	localparam logic [KIND_WIDTH-1:0] TK_PLUS    = 5'd13;
	localparam logic [KIND_WIDTH-1:0] TK_ARROW   = 5'd14;
	localparam logic [KIND_WIDTH-1:0] TK_MINUS   = 5'd15;
	localparam logic [KIND_WIDTH-1:0] TK_MULT    = 5'd16;
	localparam logic [KIND_WIDTH-1:0] TK_DIV     = 5'd17;
	localparam logic [KIND_WIDTH-1:0] TK_EQEQ    = 5'd18;
	localparam logic [KIND_WIDTH-1:0] TK_LEQ     = 5'd19;
	localparam logic [KIND_WIDTH-1:0] TK_LESS    = 5'd20;
	localparam logic [KIND_WIDTH-1:0] TK_GEQ     = 5'd21;
	localparam logic [KIND_WIDTH-1:0] TK_GTR     = 5'd22;
	localparam logic [KIND_WIDTH-1:0] TK_OTHER   = 5'd23;

	localparam logic [BYTE_WIDTH-1:0] CH_TAB     = 8'h09;
	localparam logic [BYTE_WIDTH-1:0] CH_NL      = 8'h0a;
	localparam logic [BYTE_WIDTH-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_WIDTH-1:0] CH_MINUS   = 8'h2d;
	localparam logic [BYTE_WIDTH-1:0] CH_EQUALS  = 8'h3d;
	localparam logic [BYTE_WIDTH-1:0] CH_LESS    = 8'h3c;
	localparam logic [BYTE_WIDTH-1:0] CH_GREATER = 8'h3e;
	localparam logic [BYTE_WIDTH-1:0] CH_ZERO    = 8'h30;

	typedef struct packed {
		logic [KIND_WIDTH-1:0]     kind;
		logic [VALUE_WIDTH-1:0]    value;
		logic                      ovf;
		logic [POSITION_WIDTH-1:0] start;
		logic [LENGTH_WIDTH-1:0]   length;
		logic                      last;
	} tls_result_t;

	// Results of one item, in order; only the first count slots are meaningful.
	typedef struct packed {
		logic [1:0]                         count;
		tls_result_t [MAX_RESULTS-1:0]      slot;
	} tls_push_t;

	function automatic logic is_letter(input logic [BYTE_WIDTH-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [BYTE_WIDTH-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [BYTE_WIDTH-1:0] kw_map_char(input logic [1:0] idx);
		logic [BYTE_WIDTH-1:0] r;
		unique case (idx)
			2'd0:    r = "m";
			2'd1:    r = "a";
			2'd2:    r = "p";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_WIDTH-1:0] kw_return_char(input logic [2:0] idx);
		logic [BYTE_WIDTH-1:0] r;
		unique case (idx)
			3'd0:    r = "r";
			3'd1:    r = "e";
			3'd2:    r = "t";
			3'd3:    r = "u";
			3'd4:    r = "r";
			3'd5:    r = "n";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [KIND_WIDTH-1:0] single_symbol(input logic [BYTE_WIDTH-1:0] c);
		logic [KIND_WIDTH-1:0] k;
		unique case (c)
			":":     k = TK_COLON;
			";":     k = TK_SEMI;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			",":     k = TK_COMMA;
			".":     k = TK_PERIOD;
			"+":     k = TK_PLUS;
			"*":     k = TK_MULT;
			"/":     k = TK_DIV;
			default: k = TK_OTHER;
		endcase
		return k;
	endfunction

	function automatic tls_result_t mk_result(
		input logic [KIND_WIDTH-1:0]     kind,
		input logic [VALUE_WIDTH-1:0]    value,
		input logic                      ovf,
		input logic [POSITION_WIDTH-1:0] start,
		input logic [LENGTH_WIDTH-1:0]   length,
		input logic                      last
	);
		tls_result_t r;
		r.kind   = kind;
		r.value  = value;
		r.ovf    = ovf;
		r.start  = start;
		r.length = length;
		r.last   = last;
		return r;
	endfunction

endpackage

// ===== sv/tls_lexer.sv =====
`include "token_lexer_stream_top_macros.svh"

module tls_lexer
	import tls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [BYTE_WIDTH-1:0] in_byte,
	input  logic                  in_present,
	input  logic                  in_end,
	output tls_push_t             push
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_MINUS  = 3'd3;
	localparam logic [2:0] MODE_EQ     = 3'd4;
	localparam logic [2:0] MODE_LESS   = 3'd5;
	localparam logic [2:0] MODE_GTR    = 3'd6;

	localparam int ACC_EXT = VALUE_WIDTH + 4;

	typedef struct packed {
		logic [2:0]                mode;
		logic [2:0]                kwp;
		logic [VALUE_WIDTH-1:0]    acc;
		logic                      ovf;
		logic [POSITION_WIDTH-1:0] pstart;
		logic [LENGTH_WIDTH-1:0]   plen;
		logic [POSITION_WIDTH-1:0] pos;
	} tls_state_t;

	logic                  valid_s1;
	logic [BYTE_WIDTH-1:0] byte_s1;
	logic                  present_s1;
	logic                  end_s1;

	tls_state_t state_q;
	tls_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1    <= in_byte;
			present_s1 <= in_present;
			end_s1     <= in_end;
		end
	end

	function automatic tls_result_t flush_of(input tls_state_t s);
		tls_result_t r;
		logic [KIND_WIDTH-1:0] k;
		r = '0;
		unique case (s.mode)
			MODE_IDENT: begin
				k = TK_IDENT;
				if (s.kwp == 3'd1 && s.plen == LENGTH_WIDTH'(3))
					k = TK_MAP;
				if (s.kwp == 3'd2 && s.plen == LENGTH_WIDTH'(6))
					k = TK_RETURN;
				r = mk_result(k, '0, 1'b0, s.pstart, s.plen, 1'b0);
			end
			MODE_NUMBER: r = mk_result(TK_INT, s.acc, s.ovf, s.pstart, s.plen, 1'b0);
			MODE_MINUS:  r = mk_result(TK_MINUS, '0, 1'b0, s.pstart, LENGTH_WIDTH'(1), 1'b0);
			MODE_EQ:     r = mk_result(TK_OTHER, '0, 1'b0, s.pstart, LENGTH_WIDTH'(1), 1'b0);
			MODE_LESS:   r = mk_result(TK_LESS, '0, 1'b0, s.pstart, LENGTH_WIDTH'(1), 1'b0);
			MODE_GTR:    r = mk_result(TK_GTR, '0, 1'b0, s.pstart, LENGTH_WIDTH'(1), 1'b0);
			default:     r = '0;
		endcase
		return r;
	endfunction

	tls_state_t                    st;
	tls_result_t [MAX_RESULTS-1:0] res;
	logic [1:0]                    n;
	logic [BYTE_WIDTH-1:0]         c;
	logic [ACC_EXT-1:0]            acc_ext;
	logic [ACC_EXT-1:0]            acc_wide;
	logic [LENGTH_WIDTH-1:0]       plen_inc;

	always_comb begin
		st = state_q;
		if (st.mode > MODE_GTR)
			st.mode = MODE_IDLE;
		state_nxt = st;
		res       = '0;
		n         = 2'd0;
		c         = byte_s1;
		// Multiply by ten as two shifts and an add, then the digit.
		acc_ext   = ACC_EXT'(st.acc);
		acc_wide  = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT'(c - CH_ZERO);
		plen_inc  = (st.plen == '1) ? st.plen : st.plen + LENGTH_WIDTH'(1);

		if (valid_s1 && present_s1) begin
			priority if (st.mode == MODE_MINUS && c == CH_GREATER) begin
				res[n] = mk_result(TK_ARROW, '0, 1'b0, st.pstart, LENGTH_WIDTH'(2), 1'b0);
				n = n + 2'd1;
				state_nxt.mode = MODE_IDLE;
			end else if (st.mode == MODE_EQ && c == CH_EQUALS) begin
				res[n] = mk_result(TK_EQEQ, '0, 1'b0, st.pstart, LENGTH_WIDTH'(2), 1'b0);
				n = n + 2'd1;
				state_nxt.mode = MODE_IDLE;
			end else if (st.mode == MODE_LESS && c == CH_EQUALS) begin
				res[n] = mk_result(TK_LEQ, '0, 1'b0, st.pstart, LENGTH_WIDTH'(2), 1'b0);
				n = n + 2'd1;
				state_nxt.mode = MODE_IDLE;
			end else if (st.mode == MODE_GTR && c == CH_EQUALS) begin
				res[n] = mk_result(TK_GEQ, '0, 1'b0, st.pstart, LENGTH_WIDTH'(2), 1'b0);
				n = n + 2'd1;
				state_nxt.mode = MODE_IDLE;
			end else if (st.mode == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
				// The keyword candidate survives only while each byte matches in place.
				if (st.kwp == 3'd1) begin
					if (st.plen >= LENGTH_WIDTH'(3) || kw_map_char(st.plen[1:0]) != c)
						state_nxt.kwp = 3'd0;
				end else if (st.kwp == 3'd2) begin
					if (st.plen >= LENGTH_WIDTH'(6) || kw_return_char(st.plen[2:0]) != c)
						state_nxt.kwp = 3'd0;
				end else begin
					state_nxt.kwp = 3'd0;
				end
				state_nxt.plen = plen_inc;
			end else if (st.mode == MODE_NUMBER && is_digit(c)) begin
				if (acc_wide[ACC_EXT-1:VALUE_WIDTH] != '0)
					state_nxt.ovf = 1'b1;
				state_nxt.acc  = acc_wide[VALUE_WIDTH-1:0];
				state_nxt.plen = plen_inc;
			end else begin
				if (st.mode != MODE_IDLE) begin
					res[n] = flush_of(st);
					n = n + 2'd1;
				end
				state_nxt.mode   = MODE_IDLE;
				state_nxt.pstart = st.pos;
				state_nxt.plen   = LENGTH_WIDTH'(1);
				priority if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
					state_nxt.mode = MODE_IDLE;
				end else if (is_letter(c)) begin
					state_nxt.mode = MODE_IDENT;
					state_nxt.kwp  = (c == "m") ? 3'd1 : ((c == "r") ? 3'd2 : 3'd0);
				end else if (is_digit(c)) begin
					state_nxt.mode = MODE_NUMBER;
					state_nxt.acc  = VALUE_WIDTH'(c - CH_ZERO);
					state_nxt.ovf  = 1'b0;
				end else if (c == CH_MINUS) begin
					state_nxt.mode = MODE_MINUS;
				end else if (c == CH_EQUALS) begin
					state_nxt.mode = MODE_EQ;
				end else if (c == CH_LESS) begin
					state_nxt.mode = MODE_LESS;
				end else if (c == CH_GREATER) begin
					state_nxt.mode = MODE_GTR;
				end else begin
					res[n] = mk_result(single_symbol(c), '0, 1'b0, st.pos,
						LENGTH_WIDTH'(1), 1'b0);
					n = n + 2'd1;
				end
			end
			state_nxt.pos = st.pos + POSITION_WIDTH'(1);
		end

		if (valid_s1 && end_s1) begin
			if (state_nxt.mode != MODE_IDLE) begin
				res[n] = flush_of(state_nxt);
				n = n + 2'd1;
			end
			res[n] = mk_result(TK_END, '0, 1'b0, state_nxt.pos, '0, 1'b1);
			n = n + 2'd1;
			state_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1) begin
			state_q <= state_nxt;
		end
	end

	assign push.count = n;
	assign push.slot  = res;

	`TLS_ASSERT_NEXT(a_end_resets, clk, arst_n, valid_s1 && end_s1,
		state_q.pos == '0 && state_q.mode == MODE_IDLE, "state not cleared after end beat")
	`TLS_ASSERT_IMP(a_end_closes, clk, arst_n, valid_s1 && end_s1,
		push.count != 2'd0 && push.slot[push.count - 2'd1].last, "end beat gave no End token")

endmodule

// ===== sv/tls_fifo.sv =====
`include "token_lexer_stream_top_macros.svh"

module tls_fifo
	import tls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tls_push_t   push,
	output logic        out_valid,
	input  logic        out_ready,
	output tls_result_t head,
	output logic        room
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	tls_result_t      fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign head      = fifo_q[rd_ptr_q];
	// Room for the item in flight plus one more, each up to the full burst of results.
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2 * MAX_RESULTS);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push.count)
				fifo_q[wr_ptr_q + PTR_W'(i)] <= push.slot[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`TLS_ASSERT(a_no_overrun, clk, arst_n,
		({1'b0, count_q} + (CNT_W + 1)'(push.count)) <= (CNT_W + 1)'(FIFO_DEPTH),
		"result queue overrun")
	`TLS_ASSERT_NEXT(a_count_track, clk, arst_n, 1'b1,
		count_q == $past(count_q) + CNT_W'($past(push.count)) - CNT_W'($past(pop)),
		"result queue count out of step")

endmodule

// ===== sv/token_lexer_stream_top.sv =====
// A byte beat is registered in the input stage; its tokens are written into the result queue at the next edge.
// Throughput: one byte beat per cycle while the eight-entry result queue holds two or fewer
// tokens; an item can raise up to three tokens, and the queue drains one token per cycle while m_tready is high.
// Reset: arst_n clears the lexer state, the input stage valid and the queue pointers;
// the first byte after reset, or after an End token, sits at offset zero.
`include "token_lexer_stream_top_macros.svh"

module token_lexer_stream_top
	import tls_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [BYTE_WIDTH-1:0]    s_tdata,  // char_byte
	input  logic                     s_tuser,  // char_present
	input  logic                     s_tlast,  // end_of_input
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_WIDTH-1:0] m_tdata,  // int_value, value_overflow, token_start, token_length
	output logic [KIND_WIDTH-1:0]    m_tuser,  // kind of token
	output logic                     m_tlast   // last
);

	tls_push_t   push;
	tls_result_t head;
	logic        room;

	assign s_tready = room;

	tls_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid && s_tready),
		.in_byte    (s_tdata),
		.in_present (s_tuser),
		.in_end     (s_tlast),
		.push       (push)
	);

	tls_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head),
		.room      (room)
	);

	assign m_tdata = M_TDATA_WIDTH'({head.length, head.start, head.ovf, head.value});
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	`TLS_ASSERT_IMP(a_last_is_end, clk, arst_n, m_tvalid && m_tlast, m_tuser == TK_END,
		"last beat is not an End token")

endmodule
